/* hdl/adf_pkg.sv */
// ============================================================================
// adf_pkg: shared definitions for the audio DMA queue controller
// Request kinds, register indexes, field masks, clock constants and the
// status bundle of the shared divider.
// ============================================================================
package adf_pkg;

    // Queue geometry
    localparam int QUEUE_DEPTH = 2;
    localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int SLOT_W      = $clog2(QUEUE_DEPTH);

    // Field widths
    localparam int ADDR_W    = 24;
    localparam int LEN_W     = 18;
    localparam int DACRATE_W = 14;
    localparam int BITRATE_W = 4;
    localparam int SAMPLES_W = LEN_W - 2;

    // Shared divider widths: 26-bit clock constant times 16-bit sample count
    localparam int DIVIDEND_W = 42;
    localparam int DIVISOR_W  = 26;

    // Request kinds
    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    // Register indexes
    localparam logic [2:0] REG_ADDR    = 3'd0;
    localparam logic [2:0] REG_LEN     = 3'd1;
    localparam logic [2:0] REG_CTRL    = 3'd2;
    localparam logic [2:0] REG_STATUS  = 3'd3;
    localparam logic [2:0] REG_DACRATE = 3'd4;
    localparam logic [2:0] REG_BITRATE = 3'd5;

    // Write masks
    localparam logic [ADDR_W-1:0] ADDR_MASK = 24'hFFFFF8;
    localparam logic [LEN_W-1:0]  LEN_MASK  = 18'h3FFF8;

    // Clock constants for the completion countdown
    localparam logic [DIVISOR_W-1:0] DAC_CLOCK  = 26'd48681812;
    localparam logic [DIVISOR_W-1:0] TICK_CLOCK = 26'd62500000;

    // Divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

/* hdl/adf_divider.sv */
// ============================================================================
// adf_divider: iterative restoring divider
// Produces one quotient bit per cycle; done pulses in the cycle after the last
// step, and the quotient holds until the next start.
// ============================================================================
module adf_divider #(
    parameter int DIVIDEND_W = adf_pkg::DIVIDEND_W,
    parameter int DIVISOR_W  = adf_pkg::DIVISOR_W
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [DIVIDEND_W-1:0]  dividend,
    input  logic [DIVISOR_W-1:0]   divisor,
    output logic [DIVIDEND_W-1:0]  quotient,
    output adf_pkg::div_status_t   status
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  dvs_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;
    logic [DIVISOR_W-1:0]  rem_next;
    logic [DIVIDEND_W-1:0] quo_next;

    // Shift in the next dividend bit and try the subtraction
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff     = shifted - {1'b0, dvs_reg};
        fits     = ~diff[DIVISOR_W];
        rem_next = fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
        quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
    end

    // Step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(DIVIDEND_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

/* hdl/audio_dma_fifo_controller.sv */
// ============================================================================
// audio_dma_fifo_controller: audio register block with a two-entry DMA queue
// Handles register reads, register writes and clock ticks; queues DMA
// entries on length writes and counts down to each entry's completion.
// ============================================================================
//
//  Channel | Handshake          | Payload
//  --------+--------------------+----------------------------------------------
//  input   | in_valid/in_ready  | kind, reg_index, write_data
//  output  | out_valid/out_ready| read_data, irq_raise, irq_clear, dma_start,
//          |                    | dma_address, dma_length
//
//  A request that starts no nonzero-length entry goes via S_OUT to the output
//  register. One that starts such an entry first runs two divisions (42 steps
//  each) on the shared one-bit-per-cycle divider, in S_FREQ and S_COUNT.
//  in_ready is high only while the sequencer is idle; a finished result waits
//  in the output register while the next request is taken. Reset clears the
//  sequencer, out_valid and the register state, and leaves the queue empty.
//
module audio_dma_fifo_controller (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   kind,
    input  logic [2:0]                   reg_index,
    input  logic [31:0]                  write_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [31:0]                  read_data,
    output logic                         irq_raise,
    output logic                         irq_clear,
    output logic                         dma_start,
    output logic [adf_pkg::ADDR_W-1:0]   dma_address,
    output logic [adf_pkg::LEN_W-1:0]    dma_length
);

    localparam int AW = adf_pkg::ADDR_W;
    localparam int LW = adf_pkg::LEN_W;
    localparam int CW = adf_pkg::COUNT_W;
    localparam int SW = adf_pkg::SLOT_W;
    localparam int NW = adf_pkg::DIVIDEND_W;
    localparam int DW = adf_pkg::DIVISOR_W;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_FREQ  = 4'b0010,
        S_COUNT = 4'b0100,
        S_OUT   = 4'b1000
    } state_t;

    state_t state_reg;

    // Architectural registers
    logic [AW-1:0]                  addr_reg;
    logic [LW-1:0]                  len_reg;
    logic [31:0]                    ctrl_reg;
    logic                           full_reg;
    logic                           busy_reg;
    logic [adf_pkg::DACRATE_W-1:0]  dacrate_reg;
    logic [adf_pkg::BITRATE_W-1:0]  bitrate_reg;
    logic [SW-1:0]                  rslot_reg;
    logic [SW-1:0]                  wslot_reg;
    logic [CW-1:0]                  count_reg;
    logic [31:0]                    countdown_reg;
    logic [AW-1:0]                  ent_addr_reg [adf_pkg::QUEUE_DEPTH];
    logic [LW-1:0]                  ent_len_reg  [adf_pkg::QUEUE_DEPTH];

    // Next values computed for an accepted request
    logic [AW-1:0]                  addr_next;
    logic [LW-1:0]                  len_next;
    logic [31:0]                    ctrl_next;
    logic                           full_next;
    logic                           busy_next;
    logic [adf_pkg::DACRATE_W-1:0]  dacrate_next;
    logic [adf_pkg::BITRATE_W-1:0]  bitrate_next;
    logic [SW-1:0]                  rslot_next;
    logic [SW-1:0]                  wslot_next;
    logic [CW-1:0]                  count_next;
    logic [31:0]                    countdown_next;

    logic                           ent_we;
    logic [LW-1:0]                  len_wr;
    logic                           do_start;
    logic [AW-1:0]                  start_addr;
    logic [LW-1:0]                  start_len;
    logic                           need_div;
    logic [31:0]                    read_word;

    // Result held while the countdown is computed
    logic [31:0]                    res_read_next;
    logic                           res_raise_next;
    logic                           res_clear_next;
    logic                           res_start_next;
    logic [AW-1:0]                  res_addr_next;
    logic [LW-1:0]                  res_len_next;
    logic [31:0]                    res_read_reg;
    logic                           res_raise_reg;
    logic                           res_clear_reg;
    logic                           res_start_reg;
    logic [AW-1:0]                  res_addr_reg;
    logic [LW-1:0]                  res_len_reg;
    logic [adf_pkg::SAMPLES_W-1:0]  samples_reg;

    // Output register
    logic                           out_valid_reg;
    logic [31:0]                    out_read_reg;
    logic                           out_raise_reg;
    logic                           out_clear_reg;
    logic                           out_start_reg;
    logic [AW-1:0]                  out_addr_reg;
    logic [LW-1:0]                  out_len_reg;

    // Divider hookup
    logic                           div_start;
    logic [NW-1:0]                  div_dividend;
    logic [DW-1:0]                  div_divisor;
    logic [NW-1:0]                  div_quotient;
    adf_pkg::div_status_t           div_stat;

    logic                           accept;
    logic                           out_free;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // Register read mux
    always_comb
    begin
        unique case (reg_index)
            adf_pkg::REG_ADDR:    read_word = {8'd0, addr_reg};
            adf_pkg::REG_LEN:     read_word = full_reg ? {14'd0, len_reg} : 32'd0;
            adf_pkg::REG_CTRL:    read_word = ctrl_reg;
            adf_pkg::REG_STATUS:  read_word = {full_reg, busy_reg, 29'd0, full_reg};
            adf_pkg::REG_DACRATE: read_word = {18'd0, dacrate_reg};
            adf_pkg::REG_BITRATE: read_word = {28'd0, bitrate_reg};
            default:              read_word = 32'd0;
        endcase
    end

    // Work out the effect of one request, apart from a countdown that a division yields
    always_comb
    begin
        addr_next      = addr_reg;
        len_next       = len_reg;
        ctrl_next      = ctrl_reg;
        full_next      = full_reg;
        busy_next      = busy_reg;
        dacrate_next   = dacrate_reg;
        bitrate_next   = bitrate_reg;
        rslot_next     = rslot_reg;
        wslot_next     = wslot_reg;
        count_next     = count_reg;
        countdown_next = countdown_reg;
        ent_we         = 1'b0;
        do_start       = 1'b0;
        need_div       = 1'b0;
        len_wr         = write_data[LW-1:0] & adf_pkg::LEN_MASK;
        res_read_next  = 32'd0;
        res_raise_next = 1'b0;
        res_clear_next = 1'b0;
        res_start_next = 1'b0;
        res_addr_next  = '0;
        res_len_next   = '0;

        case (kind)
            adf_pkg::KIND_READ:
            begin
                res_read_next = read_word;
            end
            adf_pkg::KIND_WRITE:
            begin
                unique case (reg_index)
                    adf_pkg::REG_ADDR:
                        addr_next = write_data[AW-1:0] & adf_pkg::ADDR_MASK;
                    adf_pkg::REG_LEN:
                    begin
                        len_next = len_wr;
                        // Queue an entry unless the queue is full
                        if (count_reg < CW'(adf_pkg::QUEUE_DEPTH))
                        begin
                            ent_we     = 1'b1;
                            wslot_next = wslot_reg + SW'(1);
                            count_next = count_reg + CW'(1);
                            if (count_next == CW'(adf_pkg::QUEUE_DEPTH))
                                full_next = 1'b1;
                            if (!busy_reg)
                            begin
                                full_next = 1'b0;
                                busy_next = 1'b1;
                                do_start  = 1'b1;
                            end
                        end
                    end
                    adf_pkg::REG_CTRL:
                        ctrl_next = write_data;
                    adf_pkg::REG_STATUS:
                        res_clear_next = 1'b1;
                    adf_pkg::REG_DACRATE:
                        dacrate_next = write_data[adf_pkg::DACRATE_W-1:0];
                    adf_pkg::REG_BITRATE:
                        bitrate_next = write_data[adf_pkg::BITRATE_W-1:0];
                    default:
                        ;
                endcase
            end
            adf_pkg::KIND_TICK:
            begin
                // Advance the countdown and retire the entry on expiry
                if (countdown_reg != 32'd0)
                begin
                    countdown_next = countdown_reg - 32'd1;
                    if (countdown_next == 32'd0 && count_reg != '0)
                    begin
                        res_raise_next = 1'b1;
                        rslot_next     = rslot_reg + SW'(1);
                        full_next      = 1'b0;
                        busy_next      = 1'b0;
                        count_next     = count_reg - CW'(1);
                        if (count_next != '0)
                        begin
                            busy_next = 1'b1;
                            do_start  = 1'b1;
                        end
                    end
                end
            end
            default:
                ;
        endcase

        // Pick the head entry, forwarding one queued by this request
        start_addr = ent_addr_reg[rslot_next];
        start_len  = ent_len_reg[rslot_next];
        if (ent_we && wslot_reg == rslot_next)
        begin
            start_addr = addr_reg;
            start_len  = len_wr;
        end

        // Start the head entry; retire a zero-length one at once
        if (do_start)
        begin
            res_start_next = 1'b1;
            res_addr_next  = start_addr;
            res_len_next   = start_len;
            if (start_len != '0)
            begin
                need_div = 1'b1;
            end
            else
            begin
                res_raise_next = 1'b1;
                rslot_next     = rslot_next + SW'(1);
                full_next      = 1'b0;
                busy_next      = 1'b0;
                if (count_next != '0)
                    count_next = count_next - CW'(1);
                if (count_next != '0)
                begin
                    busy_next      = 1'b1;
                    countdown_next = 32'd1;
                end
            end
        end
    end

    // Launch the rate division on accept, then the countdown division
    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = NW'(adf_pkg::DAC_CLOCK);
        div_divisor  = DW'({1'b0, dacrate_reg} + 15'd1);
        if (accept && need_div)
        begin
            div_start = 1'b1;
        end
        else if (state_reg == S_FREQ && div_stat.done)
        begin
            div_start    = 1'b1;
            div_dividend = NW'(adf_pkg::TICK_CLOCK) * NW'(samples_reg);
            div_divisor  = div_quotient[DW-1:0];
        end
    end

    adf_divider #(
        .DIVIDEND_W (NW),
        .DIVISOR_W  (DW)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .status   (div_stat)
    );

    // Sequencer and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            addr_reg      <= '0;
            len_reg       <= '0;
            ctrl_reg      <= '0;
            full_reg      <= 1'b0;
            busy_reg      <= 1'b0;
            dacrate_reg   <= '0;
            bitrate_reg   <= '0;
            rslot_reg     <= '0;
            wslot_reg     <= '0;
            count_reg     <= '0;
            countdown_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        addr_reg      <= addr_next;
                        len_reg       <= len_next;
                        ctrl_reg      <= ctrl_next;
                        full_reg      <= full_next;
                        busy_reg      <= busy_next;
                        dacrate_reg   <= dacrate_next;
                        bitrate_reg   <= bitrate_next;
                        rslot_reg     <= rslot_next;
                        wslot_reg     <= wslot_next;
                        count_reg     <= count_next;
                        countdown_reg <= countdown_next;
                        state_reg     <= need_div ? S_FREQ : S_OUT;
                    end
                end
                S_FREQ:
                begin
                    if (div_stat.done)
                        state_reg <= S_COUNT;
                end
                S_COUNT:
                begin
                    if (div_stat.done)
                    begin
                        countdown_reg <= div_quotient[31:0];
                        state_reg     <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // Queue entries and held result
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (ent_we)
            begin
                ent_addr_reg[wslot_reg] <= addr_reg;
                ent_len_reg[wslot_reg]  <= len_wr;
            end
            samples_reg   <= start_len[LW-1:2];
            res_read_reg  <= res_read_next;
            res_raise_reg <= res_raise_next;
            res_clear_reg <= res_clear_next;
            res_start_reg <= res_start_next;
            res_addr_reg  <= res_addr_next;
            res_len_reg   <= res_len_next;
        end
    end

    // Output register: hold until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (state_reg == S_OUT && out_free)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUT && out_free)
        begin
            out_read_reg  <= res_read_reg;
            out_raise_reg <= res_raise_reg;
            out_clear_reg <= res_clear_reg;
            out_start_reg <= res_start_reg;
            out_addr_reg  <= res_addr_reg;
            out_len_reg   <= res_len_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign read_data   = out_read_reg;
    assign irq_raise   = out_raise_reg;
    assign irq_clear   = out_clear_reg;
    assign dma_start   = out_start_reg;
    assign dma_address = out_addr_reg;
    assign dma_length  = out_len_reg;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(adf_pkg::QUEUE_DEPTH))
        else $error("entry count exceeds queue depth");

    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> count_reg == '0)
        else $error("queue holds entries while no transfer is busy");

    a_div_launch: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while still busy");

    a_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !div_stat.busy)
        else $error("sequencer idle while divider runs");

endmodule
